>>> src/rledc_pkg.sv
// ----------------------------------------------------------------------------
// rledc_pkg
// Types, constants and BCD helpers shared by the run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rledc_pkg;

  localparam int unsigned Digits = 5;
  localparam int unsigned RunW = 4 * Digits;
  localparam int unsigned CntW = 3;
  localparam logic [7:0] AsciiZero = 8'h30;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_item;
    logic       end_of_code;
  } out_item_t;

  // One unit of output work: count digits (most significant in the top nibble),
  // then an optional literal byte.
  typedef struct packed {
    logic            valid;
    logic [CntW-1:0] dig_cnt;
    logic [RunW-1:0] digits;
    logic            has_lit;
    logic [7:0]      lit_byte;
    logic            eot;
  } job_t;

  typedef struct packed {
    logic            open;
    logic [RunW-1:0] run_bcd;
  } run_status_t;

  function automatic logic [RunW-1:0] to_bcd(int unsigned value);
    logic [RunW-1:0] r;
    int unsigned v;
    r = '0;
    v = value;
    for (int i = 0; i < Digits; i++) begin
      r[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  function automatic logic [RunW-1:0] bcd_inc(logic [RunW-1:0] bcd);
    logic [RunW-1:0] r;
    logic            carry;
    logic [3:0]      d;
    r = '0;
    carry = 1'b1;
    for (int i = 0; i < Digits; i++) begin
      d = bcd[4*i +: 4];
      if (carry && d == 4'd9) begin
        r[4*i +: 4] = 4'd0;
      end else begin
        r[4*i +: 4] = d + {3'b000, carry};
        carry = 1'b0;
      end
    end
    return r;
  endfunction

  // Number of digits to print for a count; zero when the count is 0 or 1.
  function automatic logic [CntW-1:0] count_len(logic [RunW-1:0] bcd);
    logic [CntW-1:0] len;
    len = '0;
    for (int i = 0; i < Digits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) len = CntW'(i + 1);
    end
    if (bcd[RunW-1:4] == '0 && bcd[3:0] <= 4'd1) len = '0;
    return len;
  endfunction

endpackage

`default_nettype wire

>>> src/rle_decimal_count_encoder.sv
// ----------------------------------------------------------------------------
// rle_decimal_count_encoder
// Run-length encoder that writes run counts as ASCII decimal digits.
// ----------------------------------------------------------------------------
// Each text item is folded into the open run in the cycle it is accepted and
// becomes one job: the digits of a closed or flushed run (only when the count
// exceeds one), then the new literal byte. The single output register sends
// one byte per cycle unless stalled, so an item that yields several bytes
// holds the input until its last byte is sent; an item that yields one byte
// or none keeps one item per cycle unless stalled. A run reaching MAX_RUN
// (limited to 1..99999) is closed and restarted. After an end-of-text item
// the encoder is back in its reset state. No start-up sweep is needed.
`default_nettype none

module rle_decimal_count_encoder
  import rledc_pkg::*;
#(
  parameter int unsigned MAX_RUN = 65535
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned RunCap =
      (MAX_RUN > 99999) ? 99999 : ((MAX_RUN < 1) ? 1 : MAX_RUN);
  localparam logic [RunW-1:0] CapBcd = to_bcd(RunCap);

  logic        in_take;
  job_t        job;
  run_status_t status;

  assign in_take = in_valid_i && in_ready_o;

  rledc_run_tracker #(
    .CAP_BCD (CapBcd)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_take),
    .item_i   (in_item_i),
    .job_o    (job),
    .status_o (status)
  );

  rledc_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_take),
    .job_i       (job),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.end_of_code |-> out_item_o.last_of_item)
    else $error("end of code without last of item");

  a_eot_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && in_item_i.end_of_text |=> !status.open && status.run_bcd == '0)
    else $error("run still open after end of text");

  a_run_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.run_bcd <= CapBcd)
    else $error("run length beyond cap");

  a_idle_run_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.open |-> status.run_bcd == '0)
    else $error("run count held with no open run");
`endif

endmodule

`default_nettype wire

>>> src/rledc_run_tracker.sv
// ----------------------------------------------------------------------------
// rledc_run_tracker
// Holds the open run and turns each accepted item into one output job.
// ----------------------------------------------------------------------------
`default_nettype none

module rledc_run_tracker
  import rledc_pkg::*;
#(
  parameter logic [RunW-1:0] CAP_BCD = 20'h65535
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire in_item_t    item_i,
  output job_t             job_o,
  output run_status_t      status_o
);

  logic [7:0]      prior_q, prior_d;
  logic            valid_q, valid_d;
  logic [RunW-1:0] run_q, run_d;

  logic            same;
  logic            at_cap;
  logic [RunW-1:0] count_src;
  logic [CntW-1:0] len;

  always_comb begin
    same    = valid_q && (item_i.text_byte == prior_q);
    // BCD words order the same way as their values
    at_cap  = run_q >= CAP_BCD;
    prior_d = prior_q;
    valid_d = 1'b1;
    job_o   = '0;

    if (same && !at_cap) begin
      run_d         = bcd_inc(run_q);
      job_o.has_lit = 1'b0;
    end else begin
      // close the current run, restart at one
      run_d         = RunW'(1);
      job_o.has_lit = 1'b1;
      prior_d       = item_i.text_byte;
    end

    // a literal follows the closed run; otherwise only an end flush prints digits
    if (job_o.has_lit) begin
      count_src = run_q;
    end else if (item_i.end_of_text) begin
      count_src = run_d;
    end else begin
      count_src = '0;
    end

    len            = count_len(count_src);
    job_o.dig_cnt  = len;
    job_o.digits   = count_src << {(CntW'(Digits) - len), 2'b00};
    job_o.lit_byte = item_i.text_byte;
    job_o.eot      = item_i.end_of_text;
    job_o.valid    = job_o.has_lit || (len != '0);

    if (item_i.end_of_text) begin
      prior_d = '0;
      valid_d = 1'b0;
      run_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= '0;
      valid_q <= 1'b0;
      run_q   <= '0;
    end else if (accept_i) begin
      prior_q <= prior_d;
      valid_q <= valid_d;
      run_q   <= run_d;
    end
  end

  assign status_o.open    = valid_q;
  assign status_o.run_bcd = run_q;

endmodule

`default_nettype wire

>>> src/rledc_emitter.sv
// ----------------------------------------------------------------------------
// rledc_emitter
// Job register and output register; serializes one job into output items.
// ----------------------------------------------------------------------------
`default_nettype none

module rledc_emitter
  import rledc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        take_i,
  input  wire job_t        job_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o
);

  job_t      job_q, job_d;
  out_item_t out_q, sym;
  logic      out_valid_q, out_valid_d;
  logic      emit;

  always_comb begin
    emit = job_q.valid && (!out_valid_q || out_ready_i);
    if (job_q.dig_cnt != '0) begin
      sym.code_byte    = AsciiZero | {4'b0000, job_q.digits[RunW-1 -: 4]};
      sym.last_of_item = (job_q.dig_cnt == CntW'(1)) && !job_q.has_lit;
    end else begin
      sym.code_byte    = job_q.lit_byte;
      sym.last_of_item = 1'b1;
    end
    sym.end_of_code = sym.last_of_item && job_q.eot;
    ready_o = !job_q.valid || (emit && sym.last_of_item);
  end

  always_comb begin
    job_d = job_q;
    if (emit) begin
      if (sym.last_of_item) begin
        job_d.valid = 1'b0;
      end else if (job_q.dig_cnt != '0) begin
        // advance to the next digit
        job_d.dig_cnt = job_q.dig_cnt - CntW'(1);
        job_d.digits  = job_q.digits << 4;
      end
    end
    if (take_i) job_d = job_i;
    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_q       <= job_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= sym;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks rle_decimal_count_encoder against a predictor of its run-length
// encoding: literal bytes, ASCII decimal counts, the run cap, and flushing at
// end of text. Directed strings come first, with a long output stall, then
// random text with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import rledc_pkg::*;

  localparam int unsigned MaxRun = 65535;
  localparam int unsigned RunCap = (MaxRun > 99999) ? 99999 : ((MaxRun < 1) ? 1 : MaxRun);
  localparam int unsigned TotalItems = 410;
  localparam int unsigned TailItems = 60;
  localparam int unsigned SettleCycles = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Predictor state
  logic [7:0]  run_byte = 8'h00;
  logic        run_open = 1'b0;
  int unsigned run_len = 0;
  out_item_t   step_codes[$];
  out_item_t   pending_codes[$];

  bit          idle_on = 1'b0;
  int unsigned holdoff_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned codes_checked = 0;
  int unsigned strings_sent = 0;

  rle_decimal_count_encoder #(
    .MAX_RUN(MaxRun)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #(30_000_000);
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic void push_code(input logic [7:0] b);
    out_item_t c;
    c = '0;
    c.code_byte = b;
    step_codes = {step_codes, c};
  endfunction

  // Emit the open run's length as decimal digits, most significant first.
  function automatic void push_run_count();
    string digits;
    if (run_len <= 1) return;
    digits = $sformatf("%0d", run_len);
    for (int i = 0; i < digits.len(); i++) push_code(digits[i]);
  endfunction

  function automatic void encode_text_byte(input in_item_t it);
    int n;
    step_codes.delete();
    if (run_open && it.text_byte == run_byte) begin
      if (run_len >= RunCap) begin
        push_run_count();
        push_code(it.text_byte);
        run_len = 1;
      end else begin
        run_len++;
      end
    end else begin
      if (run_open) push_run_count();
      push_code(it.text_byte);
      run_len = 1;
      run_byte = it.text_byte;
      run_open = 1'b1;
    end
    if (it.end_of_text) begin
      push_run_count();
      run_open = 1'b0;
      run_len = 0;
      run_byte = 8'h00;
    end
    n = step_codes.size();
    if (n > 0) begin
      step_codes[n-1].last_of_item = 1'b1;
      step_codes[n-1].end_of_code = it.end_of_text;
    end
    pending_codes = {pending_codes, step_codes};
  endfunction

  task automatic check_code(input out_item_t got);
    out_item_t want;
    if (pending_codes.size() == 0) begin
      report_mismatch($sformatf("unexpected code byte %h", got.code_byte));
      return;
    end
    want = pending_codes.pop_front();
    codes_checked++;
    if (got.code_byte !== want.code_byte)
      report_mismatch($sformatf("code_byte %h, want %h", got.code_byte, want.code_byte));
    if (got.last_of_item !== want.last_of_item)
      report_mismatch($sformatf("last_of_item %b, want %b on byte %h",
                                got.last_of_item, want.last_of_item, want.code_byte));
    if (got.end_of_code !== want.end_of_code)
      report_mismatch($sformatf("end_of_code %b, want %b on byte %h",
                                got.end_of_code, want.end_of_code, want.code_byte));
  endtask

  // Predict on accepted items, then check accepted results, in one process.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) encode_text_byte(in_item);
      if (out_valid && out_ready) check_code(out_item);
    end
  end

  // Result side: a long hold-off on request, otherwise random stall bursts.
  always @(negedge clk_i) begin
    if (holdoff_cycles > 0) begin
      out_ready = 1'b0;
      holdoff_cycles--;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
    end
  end

  // Called at a falling edge; returns at a falling edge with valid dropped.
  task automatic send_text(input logic [7:0] b, input logic eot);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item.text_byte = b;
    in_item.end_of_text = eot;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    in_valid = 1'b0;
    items_sent++;
    if (eot) strings_sent++;
  endtask

  task automatic send_run(input logic [7:0] b, input int unsigned len, input logic eot);
    for (int unsigned i = 1; i <= len; i++) send_text(b, eot && i == len);
  endtask

  task automatic drain_codes();
    while (pending_codes.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_single_bytes();
    send_text(8'h41, 1'b1);
    // A zero byte opens a run like any other byte.
    send_run(8'h00, 3, 1'b1);
    send_text(8'hFF, 1'b1);
    send_text(8'h00, 1'b1);
    send_text(8'h7E, 1'b0);
    send_text(8'h81, 1'b1);
  endtask

  task automatic test_short_runs();
    send_run(8'h61, 2, 1'b0);
    send_run(8'h62, 2, 1'b0);
    send_text(8'h63, 1'b1);
    send_run(8'h78, 10, 1'b1);
    send_run(8'h55, 100, 1'b0);
    send_text(8'hAA, 1'b1);
  endtask

  task automatic test_digit_text();
    send_run(8'h31, 2, 1'b0);
    send_run(8'h32, 3, 1'b0);
    send_text(8'h39, 1'b1);
  endtask

  // Hold the output so the encoder fills and stalls its input, then pause.
  task automatic test_output_backpressure();
    @(negedge clk_i);
    holdoff_cycles = 200;
    for (int i = 0; i < 30; i++) begin
      if (i % 5 == 4) send_run(8'(i + 8'h30), 12, i == 29);
      else send_text(8'(i), i == 29);
    end
    drain_codes();
  endtask

  task automatic test_random_text();
    int unsigned runs;
    int unsigned len;
    int unsigned mode;
    logic [7:0]  alpha[2];
    logic [7:0]  b;
    logic        drop_eot;
    while (items_sent < TotalItems - TailItems) begin
      idle_on = $urandom_range(0, 3) != 0;
      mode = $urandom_range(0, 3);
      alpha[0] = 8'($urandom_range(0, 255));
      alpha[1] = 8'($urandom_range(0, 255));
      runs = $urandom_range(1, 6);
      drop_eot = $urandom_range(0, 7) == 0;
      for (int unsigned r = 0; r < runs && items_sent < TotalItems - TailItems; r++) begin
        case (mode)
          0: b = 8'($urandom_range(0, 255));
          1: b = 8'h30 + 8'($urandom_range(0, 9));
          default: b = ($urandom_range(0, 1) != 0) ? alpha[1] : alpha[0];
        endcase
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
        send_run(b, len, (r == runs - 1) && !drop_eot);
      end
    end
    // Last stretch without any idling.
    idle_on = 1'b0;
    while (items_sent < TotalItems) begin
      send_run(8'($urandom_range(0, 255)), $urandom_range(1, 12), $urandom_range(0, 3) == 0);
    end
    send_text(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_on = 1'b1;
    test_single_bytes();
    test_short_runs();
    test_digit_text();
    drain_codes();
    test_output_backpressure();
    test_random_text();
    drain_codes();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_codes.size() != 0)
      report_mismatch($sformatf("%0d code bytes never arrived", pending_codes.size()));
    $display("sent %0d text bytes in %0d strings, checked %0d code bytes",
             items_sent, strings_sent, codes_checked);
    $display("covered literals, zero bytes, multi-digit counts, long output stall");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
